// ----- src/bmpdec_pkg.sv -----
// Shared types and constants of the BMP 24-bit to ARGB decoder.
// No dependencies; every file of the block but bmpdec_if imports this package.
`default_nettype none

package bmpdec_pkg;

  // Width in bits of the internal image dimension fields.
  localparam int unsigned DIM_W     = 15;
  localparam int unsigned OUT_DIM_W = 13;
  localparam int unsigned INDEX_W   = 24;

  localparam int unsigned HDR_LEN       = 54;
  localparam logic [15:0] BMP_SIGNATURE = 16'h4D42;
  localparam logic [15:0] BMP_BPP       = 16'd24;
  localparam logic [31:0] BI_RGB        = 32'd0;
  localparam logic [7:0]  ALPHA_OPAQUE  = 8'hFF;

  localparam logic [1:0] RES_HEADER = 2'd0;
  localparam logic [1:0] RES_PIXEL  = 2'd1;
  localparam logic [1:0] RES_ERROR  = 2'd2;

  localparam logic [2:0] ERR_NONE        = 3'd0;
  localparam logic [2:0] ERR_TOO_SHORT   = 3'd1;
  localparam logic [2:0] ERR_SIGNATURE   = 3'd2;
  localparam logic [2:0] ERR_PLANES      = 3'd3;
  localparam logic [2:0] ERR_BIT_COUNT   = 3'd4;
  localparam logic [2:0] ERR_COMPRESSION = 3'd5;
  localparam logic [2:0] ERR_DIMENSIONS  = 3'd6;
  localparam logic [2:0] ERR_PLACEMENT   = 3'd7;

  localparam int unsigned APB_ADDR_W      = 3;
  localparam logic [0:0]  REG_FILE_LENGTH = 1'b0;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    CMD_HEADER,
    CMD_ERROR,
    CMD_PIXEL
  } cmd_kind_e;

  // One request from the parser to the pixel engine.
  typedef struct packed {
    cmd_kind_e            kind;
    logic [2:0]           err;
    logic [7:0]           data;
    logic [DIM_W-1:0]     width;
    logic [DIM_W-1:0]     height;
    logic                 top_down;
    logic [INDEX_W-1:0]   base;
  } cmd_t;

endpackage

`default_nettype wire

// ----- src/bmpdec_if.sv -----
// Stream interfaces of the decoder: the byte input and the result output.
// Depends on nothing; used by the top level, the parser and the pixel engine.
`default_nettype none

interface bmpdec_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;

  modport source (output valid, output data_byte, output first_byte, input ready);
  modport sink   (input valid, input data_byte, input first_byte, output ready);
endinterface

interface bmpdec_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [2:0]  error_code;
  logic [12:0] image_width;
  logic [12:0] image_height;
  logic [31:0] pixel_argb;
  logic [23:0] pixel_index;
  logic        last_pixel;

  modport source (output valid, output result_kind, output error_code, output image_width,
                  output image_height, output pixel_argb, output pixel_index,
                  output last_pixel, input ready);
  modport sink   (input valid, input result_kind, input error_code, input image_width,
                  input image_height, input pixel_argb, input pixel_index,
                  input last_pixel, output ready);
endinterface

`default_nettype wire

// ----- src/bmpdec_front.sv -----
// Header parser: accepts file bytes, latches and checks the header and
// forwards header, error and pixel-byte requests. Uses bmpdec_pkg and bmpdec_in_if.
`default_nettype none

module bmpdec_front import bmpdec_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  bmpdec_in_if.sink        in_i,
  input  wire logic [31:0] file_length_i,
  input  wire logic        q_full_i,
  output logic             push_o,
  output cmd_t             cmd_o
);

  localparam int unsigned WW     = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW     = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned RBW    = WW + 2;
  localparam int unsigned PW     = RBW + HW;
  localparam int unsigned BPW    = WW + HW;
  localparam int unsigned NEED_W = 33;

  localparam logic [31:0] POS_OFFSET = 32'd10;
  localparam logic [31:0] POS_WIDTH  = 32'd18;
  localparam logic [31:0] POS_HEIGHT = 32'd22;
  localparam logic [31:0] POS_PLANES = 32'd26;
  localparam logic [31:0] POS_BPP    = 32'd28;
  localparam logic [31:0] POS_COMP   = 32'd30;
  localparam logic [31:0] POS_CHECK  = 32'(HDR_LEN - 1);

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_SKIP,
    PH_PIXELS,
    PH_DONE
  } phase_e;

  phase_e phase_q, phase_d, cur_phase;
  logic [31:0] pos_q, pos_d, cur_pos;
  logic [15:0] sig_q, sig_d, planes_q, planes_d, bpp_q, bpp_d;
  logic [31:0] offset_q, offset_d, rw_q, rw_d, rh_q, rh_d, comp_q, comp_d;

  logic [PW-1:0]      prod_q;
  logic [NEED_W-1:0]  need_q;
  logic [INDEX_W-1:0] base_q;

  logic               accept;
  logic               top_down;
  logic [31:0]        h_abs;
  logic [WW-1:0]      w_trim;
  logic [HW-1:0]      h_trim, h_m1;
  logic [RBW-1:0]     rb_sum, row_bytes;
  logic [BPW-1:0]     bprod;
  logic               dims_bad, place_bad;
  logic [2:0]         hdr_err;
  logic [7:0]         b;

  function automatic logic [31:0] put_byte(input logic [31:0] old, input logic [1:0] k,
                                           input logic [7:0] val);
    logic [31:0] r;
    r = old;
    r[8*k +: 8] = val;
    return r;
  endfunction

  assign in_i.ready = !q_full_i;
  assign accept     = in_i.valid && in_i.ready;
  assign b          = in_i.data_byte;
  assign cur_phase  = in_i.first_byte ? PH_HEADER : phase_q;
  assign cur_pos    = in_i.first_byte ? '0 : pos_q;

  // Size arithmetic runs every cycle on the latched fields; the fields settle
  // well before the last header byte, so the registered results are current.
  assign top_down  = rh_q[31];
  assign h_abs     = top_down ? (32'd0 - rh_q) : rh_q;
  assign w_trim    = rw_q[WW-1:0];
  assign h_trim    = h_abs[HW-1:0];
  assign h_m1      = h_trim - HW'(1);
  assign rb_sum    = RBW'({w_trim, 1'b0}) + RBW'(w_trim) + RBW'(3);
  assign row_bytes = {rb_sum[RBW-1:2], 2'b00};
  assign bprod     = BPW'(h_m1) * BPW'(w_trim);

  always_ff @(posedge clk_i) begin
    prod_q <= PW'(row_bytes) * PW'(h_trim);
    need_q <= NEED_W'(offset_q) + NEED_W'(prod_q);
    base_q <= INDEX_W'(bprod);
  end

  assign dims_bad = (rw_q == '0) || rw_q[31] || (h_abs == '0) ||
                    (rw_q > 32'(MAX_WIDTH)) || (h_abs > 32'(MAX_HEIGHT));
  assign place_bad = (offset_q < 32'(HDR_LEN)) || (offset_q >= file_length_i) ||
                     (need_q > NEED_W'(file_length_i));

  always_comb begin
    if (sig_q != BMP_SIGNATURE) begin
      hdr_err = ERR_SIGNATURE;
    end else if (planes_q != 16'd1) begin
      hdr_err = ERR_PLANES;
    end else if (bpp_q != BMP_BPP) begin
      hdr_err = ERR_BIT_COUNT;
    end else if (comp_q != BI_RGB) begin
      hdr_err = ERR_COMPRESSION;
    end else if (dims_bad) begin
      hdr_err = ERR_DIMENSIONS;
    end else if (place_bad) begin
      hdr_err = ERR_PLACEMENT;
    end else begin
      hdr_err = ERR_NONE;
    end
  end

  always_comb begin
    phase_d  = phase_q;
    pos_d    = pos_q;
    sig_d    = sig_q;
    offset_d = offset_q;
    rw_d     = rw_q;
    rh_d     = rh_q;
    planes_d = planes_q;
    bpp_d    = bpp_q;
    comp_d   = comp_q;
    push_o   = 1'b0;
    cmd_o    = '0;
    cmd_o.kind = CMD_PIXEL;
    cmd_o.data = b;
    if (accept) begin
      pos_d   = cur_pos + 32'd1;
      phase_d = cur_phase;
      case (cur_phase)
        PH_HEADER: begin
          if (cur_pos == '0 && file_length_i < 32'(HDR_LEN)) begin
            push_o     = 1'b1;
            cmd_o.kind = CMD_ERROR;
            cmd_o.err  = ERR_TOO_SHORT;
            phase_d    = PH_DONE;
          end else begin
            if (cur_pos < 32'd2) begin
              sig_d = 16'(put_byte(32'(sig_q), 2'(cur_pos), b));
            end else if (cur_pos >= POS_OFFSET && cur_pos < POS_OFFSET + 32'd4) begin
              offset_d = put_byte(offset_q, 2'(cur_pos - POS_OFFSET), b);
            end else if (cur_pos >= POS_WIDTH && cur_pos < POS_WIDTH + 32'd4) begin
              rw_d = put_byte(rw_q, 2'(cur_pos - POS_WIDTH), b);
            end else if (cur_pos >= POS_HEIGHT && cur_pos < POS_HEIGHT + 32'd4) begin
              rh_d = put_byte(rh_q, 2'(cur_pos - POS_HEIGHT), b);
            end else if (cur_pos >= POS_PLANES && cur_pos < POS_PLANES + 32'd2) begin
              planes_d = 16'(put_byte(32'(planes_q), 2'(cur_pos - POS_PLANES), b));
            end else if (cur_pos >= POS_BPP && cur_pos < POS_BPP + 32'd2) begin
              bpp_d = 16'(put_byte(32'(bpp_q), 2'(cur_pos - POS_BPP), b));
            end else if (cur_pos >= POS_COMP && cur_pos < POS_COMP + 32'd4) begin
              comp_d = put_byte(comp_q, 2'(cur_pos - POS_COMP), b);
            end
            if (cur_pos == POS_CHECK) begin
              push_o = 1'b1;
              if (hdr_err != ERR_NONE) begin
                cmd_o.kind = CMD_ERROR;
                cmd_o.err  = hdr_err;
                phase_d    = PH_DONE;
              end else begin
                cmd_o.kind     = CMD_HEADER;
                cmd_o.width    = rw_q[DIM_W-1:0];
                cmd_o.height   = h_abs[DIM_W-1:0];
                cmd_o.top_down = top_down;
                cmd_o.base     = top_down ? '0 : base_q;
                phase_d        = PH_SKIP;
              end
            end
          end
        end
        PH_SKIP: begin
          if (cur_pos == offset_q) begin
            push_o  = 1'b1;
            phase_d = PH_PIXELS;
          end
        end
        PH_PIXELS: begin
          push_o = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      pos_q   <= '0;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
    end
  end

  // Every header field is rewritten before it is checked, so no reset here.
  always_ff @(posedge clk_i) begin
    sig_q    <= sig_d;
    offset_q <= offset_d;
    rw_q     <= rw_d;
    rh_q     <= rh_d;
    planes_q <= planes_d;
    bpp_q    <= bpp_d;
    comp_q   <= comp_d;
  end

endmodule

`default_nettype wire

// ----- src/bmpdec_queue.sv -----
// Short request queue between the header parser and the pixel engine.
// Uses cmd_t and the queue depth from bmpdec_pkg.
`default_nettype none

module bmpdec_queue import bmpdec_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  cmd_t      cmd_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      valid_o,
  output cmd_t      cmd_o
);

  cmd_t              entries_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;
  logic              do_push, do_pop;

  assign full_o  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign cmd_o   = entries_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

`default_nettype wire

// ----- src/bmpdec_back.sv -----
// Pixel engine: turns queued requests into header, error and ARGB pixel
// results with their destination index. Uses bmpdec_pkg and bmpdec_out_if.
`default_nettype none

module bmpdec_back import bmpdec_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic q_valid_i,
  input  cmd_t      q_cmd_i,
  output logic      q_pop_o,
  bmpdec_out_if.source out_o
);

  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);

  logic               out_valid_q, out_valid_d;
  logic               active_q, active_d;
  logic [1:0]         channel_q, channel_d, pad_q, pad_d;
  logic [WW-1:0]      col_q, col_d, img_w_q, img_w_d;
  logic [HW-1:0]      row_q, row_d, img_h_q, img_h_d;
  logic               top_down_q, top_down_d;
  logic [INDEX_W-1:0] base_q, base_d;
  logic [7:0]         blue_q, blue_d, green_q, green_d;

  logic [1:0]           kind_q, res_kind;
  logic [2:0]           err_q, res_err;
  logic [OUT_DIM_W-1:0] width_q, height_q, res_width, res_height;
  logic [31:0]          argb_q, res_argb;
  logic [INDEX_W-1:0]   index_q, res_index;
  logic                 last_q, res_last;

  logic          emit, free;
  logic [WW:0]   col_inc;
  logic [HW:0]   row_inc;
  logic          col_wrap, row_last;

  assign free    = !out_valid_q || out_o.ready;
  assign q_pop_o = q_valid_i && free;

  assign col_inc  = (WW+1)'(col_q) + (WW+1)'(1);
  assign row_inc  = (HW+1)'(row_q) + (HW+1)'(1);
  assign col_wrap = (col_inc >= (WW+1)'(img_w_q));
  assign row_last = (row_inc >= (HW+1)'(img_h_q));

  always_comb begin
    active_d   = active_q;
    channel_d  = channel_q;
    pad_d      = pad_q;
    col_d      = col_q;
    row_d      = row_q;
    img_w_d    = img_w_q;
    img_h_d    = img_h_q;
    top_down_d = top_down_q;
    base_d     = base_q;
    blue_d     = blue_q;
    green_d    = green_q;
    emit       = 1'b0;
    res_kind   = RES_HEADER;
    res_err    = ERR_NONE;
    res_width  = '0;
    res_height = '0;
    res_argb   = '0;
    res_index  = '0;
    res_last   = 1'b0;
    if (q_pop_o) begin
      case (q_cmd_i.kind)
        CMD_HEADER: begin
          emit       = 1'b1;
          res_kind   = RES_HEADER;
          res_width  = q_cmd_i.width[OUT_DIM_W-1:0];
          res_height = q_cmd_i.height[OUT_DIM_W-1:0];
          img_w_d    = q_cmd_i.width[WW-1:0];
          img_h_d    = q_cmd_i.height[HW-1:0];
          top_down_d = q_cmd_i.top_down;
          base_d     = q_cmd_i.base;
          active_d   = 1'b1;
          channel_d  = '0;
          pad_d      = '0;
          col_d      = '0;
          row_d      = '0;
        end
        CMD_ERROR: begin
          emit     = 1'b1;
          res_kind = RES_ERROR;
          res_err  = q_cmd_i.err;
          active_d = 1'b0;
        end
        CMD_PIXEL: begin
          // Bytes that follow the last pixel of an image are dropped here.
          if (active_q) begin
            if (pad_q != '0) begin
              pad_d = pad_q - 2'd1;
            end else if (channel_q == 2'd0) begin
              blue_d    = q_cmd_i.data;
              channel_d = 2'd1;
            end else if (channel_q == 2'd1) begin
              green_d   = q_cmd_i.data;
              channel_d = 2'd2;
            end else begin
              emit      = 1'b1;
              channel_d = 2'd0;
              res_kind  = RES_PIXEL;
              res_argb  = {ALPHA_OPAQUE, q_cmd_i.data, green_q, blue_q};
              res_index = base_q + INDEX_W'(col_q);
              res_last  = row_last && col_wrap;
              if (row_last && col_wrap) begin
                active_d = 1'b0;
              end else if (col_wrap) begin
                col_d  = '0;
                row_d  = row_inc[HW-1:0];
                pad_d  = img_w_q[1:0];
                base_d = top_down_q ? base_q + INDEX_W'(img_w_q)
                                    : base_q - INDEX_W'(img_w_q);
              end else begin
                col_d = col_inc[WW-1:0];
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
    out_valid_d = emit ? 1'b1 : (out_valid_q && !out_o.ready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      active_q    <= 1'b0;
      channel_q   <= '0;
      pad_q       <= '0;
      col_q       <= '0;
      row_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      active_q    <= active_d;
      channel_q   <= channel_d;
      pad_q       <= pad_d;
      col_q       <= col_d;
      row_q       <= row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    img_w_q    <= img_w_d;
    img_h_q    <= img_h_d;
    top_down_q <= top_down_d;
    base_q     <= base_d;
    blue_q     <= blue_d;
    green_q    <= green_d;
    if (emit) begin
      kind_q   <= res_kind;
      err_q    <= res_err;
      width_q  <= res_width;
      height_q <= res_height;
      argb_q   <= res_argb;
      index_q  <= res_index;
      last_q   <= res_last;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.result_kind  = kind_q;
  assign out_o.error_code   = err_q;
  assign out_o.image_width  = width_q;
  assign out_o.image_height = height_q;
  assign out_o.pixel_argb   = argb_q;
  assign out_o.pixel_index  = index_q;
  assign out_o.last_pixel   = last_q;

endmodule

`default_nettype wire

// ----- src/bmp24_to_argb_decoder_core.sv -----
// Requests cross the queue; results leave a register. Throughput: one byte per
// cycle while the queue has room, set by the single-byte parse step of the header
// parser and the one-request-per-cycle pixel engine behind a 4-entry queue.
// Reset (rst_ni low, asynchronous): parser in header phase at byte 0, queue and
// output empty, file_length 0. No clearing pass; bytes are taken right after reset.
// Depends on bmpdec_pkg, bmpdec_if, bmpdec_front, bmpdec_queue and bmpdec_back.
`default_nettype none

module bmp24_to_argb_decoder_core import bmpdec_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  bmpdec_in_if.sink                  in_i,
  bmpdec_out_if.source               out_o,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [31:0]           pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  logic [31:0] file_length_q;
  logic        cfg_write;
  logic        front_push, q_full, q_pop, q_valid;
  cmd_t        front_cmd, q_cmd;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready &&
                     (paddr[APB_ADDR_W-1:2] == REG_FILE_LENGTH);
  assign prdata    = (paddr[APB_ADDR_W-1:2] == REG_FILE_LENGTH) ? file_length_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      file_length_q <= '0;
    end else if (cfg_write) begin
      file_length_q <= pwdata;
    end
  end

  bmpdec_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_i          (in_i),
    .file_length_i (file_length_q),
    .q_full_i      (q_full),
    .push_o        (front_push),
    .cmd_o         (front_cmd)
  );

  bmpdec_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_push),
    .cmd_i   (front_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .cmd_o   (q_cmd)
  );

  bmpdec_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_cmd_i   (q_cmd),
    .q_pop_o   (q_pop),
    .out_o     (out_o)
  );

  // The parser must never issue a request into a full queue.
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    front_push |-> !q_full)
    else $error("request pushed into a full queue");

  a_pop_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("pixel engine popped an empty queue");

  a_cfg_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_write |=> (file_length_q == $past(pwdata)))
    else $error("file_length write was not taken");

endmodule

`default_nettype wire
